// ===== hdl/lmcs_pkg.sv =====
// Shared types and codes for the cascaded LED matrix command serializer.
// No dependencies.
`default_nettype none
package lmcs_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_MOD,
        ST_EMIT
    } t_state;

    localparam logic [2:0] MODE_SET_LED    = 3'd0;
    localparam logic [2:0] MODE_SET_ROW    = 3'd1;
    localparam logic [2:0] MODE_SET_COLUMN = 3'd2;
    localparam logic [2:0] MODE_CLEAR      = 3'd3;
    localparam logic [2:0] MODE_SHUTDOWN   = 3'd4;
    localparam logic [2:0] MODE_INTENSITY  = 3'd5;
    localparam logic [2:0] MODE_SCAN_LIMIT = 3'd6;
    localparam logic [2:0] MODE_RAW        = 3'd7;

    localparam logic [7:0] OPC_INTENSITY = 8'd10;
    localparam logic [7:0] OPC_SCANLIMIT = 8'd11;
    localparam logic [7:0] OPC_SHUTDOWN  = 8'd12;

    localparam logic [7:0] INTENSITY_MAX = 8'd15;
    localparam logic [7:0] SCAN_MAX      = 8'd7;
    localparam logic [7:0] COL0_MASK     = 8'h80;

    localparam logic [3:0] NDEV_RESET = 4'd8;

endpackage
`default_nettype wire

// ===== hdl/led_matrix_cascade_command_serializer.sv =====
// Cascaded 8x8 LED matrix command serializer: row image store plus frame sequencer.
// Depends on lmcs_pkg.
//
//  channel  | ports                                           | handshake
//  ---------+-------------------------------------------------+---------------------------
//  command  | i_mode i_device i_row i_column i_value          | start & !busy
//           | i_raw_opcode                                    |
//  result   | o_word o_frame_end o_last                       | o_valid, one cycle each
//  config   | i_cfg_wdata                                     | i_cfg_we
//
// Each frame reads the row image (ST_READ), then modifies/writes it (ST_MOD), then
// emits one word per device in use (ST_EMIT). Set column and clear run 8 frames, one
// per row; other commands run a single frame. A dropped command is accepted but
// leaves the sequencer idle.
// Synchronous active-low reset clears the sequencer, the row valid bits (image reads
// as zero) and sets the device count to 8. Results cannot be stalled.
`default_nettype none
module led_matrix_cascade_command_serializer #(
    parameter int MAX_DEVICES = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_mode,
    input  wire logic [2:0]  i_device,
    input  wire logic [2:0]  i_row,
    input  wire logic [2:0]  i_column,
    input  wire logic [7:0]  i_value,
    input  wire logic [3:0]  i_raw_opcode,
    input  wire logic        i_cfg_we,
    input  wire logic [3:0]  i_cfg_wdata,
    output logic             o_valid,
    output logic [15:0]      o_word,
    output logic             o_frame_end,
    output logic             o_last
);

    localparam int DEPTH = MAX_DEVICES * 8;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    lmcs_pkg::t_state r_state, n_state;

    logic [3:0]       r_num_devices;
    logic [2:0]       r_mode, r_dev, r_col, r_row, r_dcnt;
    logic [7:0]       r_value;
    logic [3:0]       r_rawop;
    logic [7:0]       r_op, r_data;
    logic [7:0]       r_rdata;
    logic             r_rvalid;
    logic [DEPTH-1:0] r_valid;
    logic [7:0]       r_mem [DEPTH];

    logic [3:0] dev_cnt;
    logic       accept, drop;
    logic [5:0] full_addr;
    logic [AW-1:0] addr;
    logic       mem_we;
    logic       multi_frame, final_frame;
    logic [7:0] old_row, mask, n_op, n_data;
    logic       led_on;

    // device count, out-of-range values fall back to the maximum
    always_comb begin
        if (r_num_devices == 4'd0 || r_num_devices > 4'(MAX_DEVICES)) begin
            dev_cnt = 4'(MAX_DEVICES);
        end else begin
            dev_cnt = r_num_devices;
        end
    end

    assign accept = start && !busy;

    always_comb begin
        drop = ({1'b0, i_device} >= dev_cnt);
        if (i_mode == lmcs_pkg::MODE_INTENSITY && i_value > lmcs_pkg::INTENSITY_MAX) begin
            drop = 1'b1;
        end
        if (i_mode == lmcs_pkg::MODE_SCAN_LIMIT && i_value > lmcs_pkg::SCAN_MAX) begin
            drop = 1'b1;
        end
    end

    assign full_addr   = {r_dev, r_row};
    assign addr        = full_addr[AW-1:0];
    assign multi_frame = (r_mode == lmcs_pkg::MODE_SET_COLUMN) || (r_mode == lmcs_pkg::MODE_CLEAR);
    assign final_frame = !multi_frame || (r_row == 3'd7);

    // shared row/word unit: one frame's opcode and data per pass
    always_comb begin
        old_row = r_rvalid ? r_rdata : 8'd0;
        mask    = lmcs_pkg::COL0_MASK >> r_col;
        led_on  = (r_mode == lmcs_pkg::MODE_SET_COLUMN) ? r_value[~r_row] : r_value[0];
        n_op    = 8'({5'd0, r_row}) + 8'd1;
        case (r_mode) inside
            lmcs_pkg::MODE_SET_LED, lmcs_pkg::MODE_SET_COLUMN: begin
                n_data = led_on ? (old_row | mask) : (old_row & ~mask);
            end
            lmcs_pkg::MODE_SET_ROW: begin
                n_data = r_value;
            end
            lmcs_pkg::MODE_CLEAR: begin
                n_data = 8'd0;
            end
            lmcs_pkg::MODE_SHUTDOWN: begin
                n_op   = lmcs_pkg::OPC_SHUTDOWN;
                n_data = (r_value != 8'd0) ? 8'd0 : 8'd1;
            end
            lmcs_pkg::MODE_INTENSITY: begin
                n_op   = lmcs_pkg::OPC_INTENSITY;
                n_data = r_value;
            end
            lmcs_pkg::MODE_SCAN_LIMIT: begin
                n_op   = lmcs_pkg::OPC_SCANLIMIT;
                n_data = r_value;
            end
            default: begin
                n_op   = {4'd0, r_rawop};
                n_data = r_value;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lmcs_pkg::ST_IDLE: begin
                if (accept && !drop) begin
                    n_state = lmcs_pkg::ST_READ;
                end
            end
            lmcs_pkg::ST_READ: begin
                n_state = lmcs_pkg::ST_MOD;
            end
            lmcs_pkg::ST_MOD: begin
                n_state = lmcs_pkg::ST_EMIT;
            end
            lmcs_pkg::ST_EMIT: begin
                if (r_dcnt == 3'd0) begin
                    n_state = final_frame ? lmcs_pkg::ST_IDLE : lmcs_pkg::ST_READ;
                end
            end
            default: begin
                n_state = lmcs_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        busy        = 1'b1;
        o_valid     = 1'b0;
        mem_we      = 1'b0;
        o_word      = 16'd0;
        o_frame_end = 1'b0;
        o_last      = 1'b0;
        unique case (r_state)
            lmcs_pkg::ST_IDLE: begin
                busy = 1'b0;
            end
            lmcs_pkg::ST_READ: begin
            end
            lmcs_pkg::ST_MOD: begin
                mem_we = (r_mode == lmcs_pkg::MODE_SET_LED) ||
                         (r_mode == lmcs_pkg::MODE_SET_ROW) || multi_frame;
            end
            lmcs_pkg::ST_EMIT: begin
                o_valid     = 1'b1;
                o_word      = (r_dcnt == r_dev) ? {r_op, r_data} : 16'd0;
                o_frame_end = (r_dcnt == 3'd0);
                o_last      = (r_dcnt == 3'd0) && final_frame;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= lmcs_pkg::ST_IDLE;
            r_num_devices <= lmcs_pkg::NDEV_RESET;
            r_valid       <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_num_devices <= i_cfg_wdata;
            end
            if (mem_we) begin
                r_valid[addr] <= 1'b1;
            end
        end
    end

    // row image store
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[addr] <= n_data;
        end
        r_rdata  <= r_mem[addr];
        r_rvalid <= r_valid[addr];
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode  <= i_mode;
            r_dev   <= i_device;
            r_col   <= i_column;
            r_value <= i_value;
            r_rawop <= i_raw_opcode;
            r_row   <= (i_mode == lmcs_pkg::MODE_SET_COLUMN || i_mode == lmcs_pkg::MODE_CLEAR)
                       ? 3'd0 : i_row;
        end
        if (r_state == lmcs_pkg::ST_MOD) begin
            r_op   <= n_op;
            r_data <= n_data;
            r_dcnt <= 3'(dev_cnt - 4'd1);
        end
        if (r_state == lmcs_pkg::ST_EMIT) begin
            r_dcnt <= r_dcnt - 3'd1;
            if (r_dcnt == 3'd0 && !final_frame) begin
                r_row <= r_row + 3'd1;
            end
        end
    end

    a_last_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> (o_valid && o_frame_end))
        else $error("last word not at frame end");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |=> !busy)
        else $error("still busy after last word");

    a_next_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_frame_end && !o_last) |=> (busy && !o_valid))
        else $error("frame sequence broken");

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("word strobed while idle");

endmodule
`default_nettype wire
